@@ design/vpi_pkg.sv @@
// Shared types and constants for the video chip port interface.
// Used by vpi_vram, vpi_ctrl and the top level; depends on nothing.
`default_nettype none

package vpi_pkg;

  localparam int VIDEO_ADDR_BITS = 14;
  localparam int PAL_IDX_BITS    = 6;
  localparam int FLAG_BITS       = 3;

  typedef logic [VIDEO_ADDR_BITS-1:0] vaddr_t;

  // request kinds
  localparam logic [2:0] REQ_CTRL_WRITE = 3'd0;
  localparam logic [2:0] REQ_DATA_WRITE = 3'd1;
  localparam logic [2:0] REQ_DATA_READ  = 3'd2;
  localparam logic [2:0] REQ_STATUS     = 3'd3;
  localparam logic [2:0] REQ_FLAGS      = 3'd4;

  // top two bits of the second control byte
  localparam logic [1:0] CODE_VRAM_READ  = 2'b00;
  localparam logic [1:0] CODE_VRAM_WRITE = 2'b01;
  localparam logic [1:0] CODE_REG_WRITE  = 2'b10;
  localparam logic [1:0] CODE_COLOUR     = 2'b11;

  localparam logic [4:0] STATUS_LOW_ONES = 5'h1F;

  // configuration register byte addresses
  localparam logic [1:0] CFG_ADDR_PALETTE_MODE = 2'd0;

  typedef struct packed {
    logic                    we;
    vaddr_t                  waddr;
    logic [7:0]              wdata;
    vaddr_t                  raddr;
  } vram_req_t;

  typedef struct packed {
    logic [7:0]              read_byte;
    logic                    reg_write_strobe;
    logic [3:0]              reg_number;
    logic [7:0]              reg_data;
    logic                    palette_write_strobe;
    logic [PAL_IDX_BITS-1:0] palette_index;
    logic [7:0]              palette_data;
  } result_t;

endpackage

`default_nettype wire

@@ design/vpi_vram.sv @@
// Video memory: one write port and one read port, read data registered.
// Depends on vpi_pkg for the address width and request struct.
`default_nettype none

module vpi_vram (
  input  wire logic               clk,
  input  wire vpi_pkg::vram_req_t req,
  output logic [7:0]              rdata
);
  import vpi_pkg::*;

  logic [7:0] mem [2**VIDEO_ADDR_BITS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

@@ design/vpi_ctrl.sv @@
// Port sequencer: byte latch, access address, read buffer, status flags,
// VRAM clearing pass and the result registers. Depends on vpi_pkg.
`default_nettype none

module vpi_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wide_palette_mode,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          req_type,
  input  wire logic [7:0]          bus_byte,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vpi_pkg::result_t         result,
  output vpi_pkg::vram_req_t       vram_req,
  input  wire logic [7:0]          vram_rdata
);
  import vpi_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ} state_t;

  state_t               state;
  vaddr_t               clr_addr;
  vaddr_t               addr;
  logic [7:0]           latch;
  logic                 second;
  logic                 ctarget;
  logic [7:0]           rbuf;
  logic [FLAG_BITS-1:0] flags;
  logic                 pend_valid;
  result_t              pend;

  vaddr_t               addr_next;
  vaddr_t               new_addr;
  logic [7:0]           latch_next;
  logic                 second_next;
  logic                 ctarget_next;
  logic [7:0]           rbuf_next;
  logic [FLAG_BITS-1:0] flags_next;
  logic                 do_read;
  logic                 vram_we;
  vaddr_t               read_addr;
  result_t              res;
  logic                 accept;
  logic                 out_free;

  assign in_stall = (state != ST_IDLE) || pend_valid;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign new_addr = {bus_byte[VIDEO_ADDR_BITS-9:0], latch};

  always_comb begin
    res          = '0;
    addr_next    = addr;
    latch_next   = latch;
    second_next  = second;
    ctarget_next = ctarget;
    rbuf_next    = rbuf;
    flags_next   = flags;
    do_read      = 1'b0;
    vram_we      = 1'b0;
    read_addr    = addr;
    case (req_type)
      REQ_CTRL_WRITE: begin
        if (!second) begin
          latch_next  = bus_byte;
          second_next = 1'b1;
          addr_next   = {addr[VIDEO_ADDR_BITS-1:8], bus_byte};
        end else begin
          second_next = 1'b0;
          addr_next   = new_addr;
          if (bus_byte[7:6] == CODE_COLOUR) begin
            ctarget_next = 1'b1;
          end else begin
            ctarget_next = 1'b0;
            if (bus_byte[7:6] == CODE_REG_WRITE) begin
              res.reg_write_strobe = 1'b1;
              res.reg_number       = bus_byte[3:0];
              res.reg_data         = latch;
            end
            if (bus_byte[7:6] == CODE_VRAM_READ) begin
              // prefetch at the new address, then step past it
              do_read   = 1'b1;
              read_addr = new_addr;
              addr_next = new_addr + VIDEO_ADDR_BITS'(1);
            end
          end
        end
      end
      REQ_DATA_WRITE: begin
        second_next = 1'b0;
        if (!ctarget) begin
          vram_we = 1'b1;
        end else begin
          res.palette_write_strobe = 1'b1;
          res.palette_index = wide_palette_mode ? addr[PAL_IDX_BITS-1:0]
                                                : {1'b0, addr[PAL_IDX_BITS-2:0]};
          res.palette_data  = bus_byte;
        end
        rbuf_next = bus_byte;
        addr_next = addr + VIDEO_ADDR_BITS'(1);
      end
      REQ_DATA_READ: begin
        second_next   = 1'b0;
        res.read_byte = rbuf;
        do_read       = 1'b1;
        addr_next     = addr + VIDEO_ADDR_BITS'(1);
      end
      REQ_STATUS: begin
        second_next   = 1'b0;
        res.read_byte = {flags, STATUS_LOW_ONES};
        flags_next    = '0;
      end
      REQ_FLAGS: begin
        flags_next = flags | bus_byte[7:5];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    vram_req.raddr = read_addr;
    if (state == ST_CLEAR) begin
      vram_req.we    = 1'b1;
      vram_req.waddr = clr_addr;
      vram_req.wdata = '0;
    end else begin
      vram_req.we    = accept && vram_we;
      vram_req.waddr = addr;
      vram_req.wdata = bus_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      addr       <= '0;
      latch      <= '0;
      second     <= 1'b0;
      ctarget    <= 1'b0;
      rbuf       <= '0;
      flags      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + VIDEO_ADDR_BITS'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && do_read) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          rbuf  <= vram_rdata;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase

      if (accept) begin
        addr    <= addr_next;
        latch   <= latch_next;
        second  <= second_next;
        ctarget <= ctarget_next;
        rbuf    <= rbuf_next;
        flags   <= flags_next;
      end

      // output word plus one holding slot behind it
      if (out_free) begin
        if (pend_valid) begin
          result     <= pend;
          out_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else if (accept) begin
          result    <= res;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (accept) begin
        pend       <= res;
        pend_valid <= 1'b1;
      end
    end
  end

  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("holding slot filled while output word empty");

  a_read_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> $past(accept))
    else $error("prefetch state entered without an accepted word");

  a_no_accept_over_pend: assert property (@(posedge clk) disable iff (rst)
    accept |-> !pend_valid)
    else $error("word accepted while holding slot occupied");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(result.reg_write_strobe && result.palette_write_strobe))
    else $error("register and palette strobes in one word");

endmodule

`default_nettype wire

@@ design/video_chip_port_interface_unit.sv @@
// Video chip CPU port interface: control, data and status ports over VRAM.
// An accepted request's result word is registered into the output word, or
// into a holding slot while the output is stalled. Data reads and VRAM-read
// control bytes stall the input until the registered read from the single-port-read VRAM is buffered.
// After reset a pass zeroes all of VRAM with the input stalled;
// the APB port accepts writes throughout. Depends on vpi_pkg, vpi_ctrl, vpi_vram.
`default_nettype none

module video_chip_port_interface_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [7:0]  bus_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_byte,
  output logic             reg_write_strobe,
  output logic [3:0]       reg_number,
  output logic [7:0]       reg_data,
  output logic             palette_write_strobe,
  output logic [5:0]       palette_index,
  output logic [7:0]       palette_data
);
  import vpi_pkg::*;

  logic       wide_palette_mode;
  result_t    result;
  vram_req_t  vram_req;
  logic [7:0] vram_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_palette_mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr == CFG_ADDR_PALETTE_MODE) begin
      wide_palette_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == CFG_ADDR_PALETTE_MODE) begin
      prdata[0] = wide_palette_mode;
    end
  end

  vpi_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .wide_palette_mode (wide_palette_mode),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .req_type          (req_type),
    .bus_byte          (bus_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result            (result),
    .vram_req          (vram_req),
    .vram_rdata        (vram_rdata)
  );

  vpi_vram u_vram (
    .clk   (clk),
    .req   (vram_req),
    .rdata (vram_rdata)
  );

  assign read_byte            = result.read_byte;
  assign reg_write_strobe     = result.reg_write_strobe;
  assign reg_number           = result.reg_number;
  assign reg_data             = result.reg_data;
  assign palette_write_strobe = result.palette_write_strobe;
  assign palette_index        = result.palette_index;
  assign palette_data         = result.palette_data;

endmodule

`default_nettype wire
